>>> rtl/sensor_packet_deframer_sum16_top_macros.svh
// Assertion macros for the sensor packet deframer.
`ifndef SENSOR_PACKET_DEFRAMER_SUM16_TOP_MACROS_SVH
`define SENSOR_PACKET_DEFRAMER_SUM16_TOP_MACROS_SVH

`ifndef SYNTH
`define SPD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("spd assertion failed");
`define SPD_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("spd invariant failed");
`else
`define SPD_ASSERT(label, clk, rst_n, prop)
`define SPD_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

>>> rtl/spd_pkg.sv
// Types and constants shared by the sensor packet deframer.
package spd_pkg;

    localparam int ERROR_COUNT_WIDTH_DEF = 16;

    localparam logic [7:0] HDR_S = 8'h73;
    localparam logic [7:0] HDR_N = 8'h6E;
    localparam logic [7:0] HDR_P = 8'h70;

    localparam logic [1:0] SEL_SHORT = 2'b00;
    localparam logic [1:0] SEL_KEEP  = 2'b01;
    localparam logic [1:0] SEL_DATA  = 2'b10;
    localparam logic [1:0] SEL_BATCH = 2'b11;

    localparam logic [6:0] LEN_SHORT = 7'd7;
    localparam logic [6:0] LEN_DATA  = 7'd11;
    localparam logic [6:0] LEN_BODY_START = 7'd5;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_GOT_S = 3'd1,
        PH_GOT_N = 3'd2,
        PH_TYPE  = 3'd3,
        PH_ADDR  = 3'd4,
        PH_BODY  = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        EV_ACCEPT   = 3'd0,
        EV_HDR_ERR  = 3'd1,
        EV_PAYLOAD  = 3'd2,
        EV_SUM_HIGH = 3'd3,
        EV_GOOD     = 3'd4,
        EV_BAD      = 3'd5
    } t_event;

    typedef struct packed {
        t_phase      phase;
        logic [6:0]  position;
        logic [6:0]  exp_len;
        logic [7:0]  kind;
        logic [7:0]  addr;
        logic [15:0] sum;
        logic [7:0]  sum_high;
    } t_spd_state;

    typedef struct packed {
        t_event     event_res;
        logic [6:0] byte_position;
    } t_step_out;

    typedef struct packed {
        t_event      event_res;
        logic [7:0]  byte_value;
        logic [6:0]  byte_position;
        logic [7:0]  packet_kind;
        logic [7:0]  register_address;
        logic [6:0]  frame_length;
        logic [15:0] header_error_total;
        logic [15:0] checksum_error_total;
    } t_spd_result;

endpackage

>>> rtl/spd_in_if.sv
// Input channel carrying one received byte per transfer.
interface spd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

>>> rtl/spd_out_if.sv
// Output channel carrying one tagged deframer result per transfer.
interface spd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [7:0]  byte_value;
    logic [6:0]  byte_position;
    logic [7:0]  packet_kind;
    logic [7:0]  register_address;
    logic [6:0]  frame_length;
    logic [15:0] header_error_total;
    logic [15:0] checksum_error_total;

    modport source (
        output valid, output event_res, output byte_value, output byte_position,
        output packet_kind, output register_address, output frame_length,
        output header_error_total, output checksum_error_total, input ready
    );
    modport sink (
        input valid, input event_res, input byte_value, input byte_position,
        input packet_kind, input register_address, input frame_length,
        input header_error_total, input checksum_error_total, output ready
    );
endinterface

>>> rtl/spd_step.sv
// Next-state and event logic of the deframer for one received byte.
module spd_step (
    input  spd_pkg::t_spd_state i_state,
    input  logic [7:0]          i_byte,
    output spd_pkg::t_spd_state o_state,
    output spd_pkg::t_step_out  o_step
);
    import spd_pkg::*;

    logic [7:0]  w_pos_plus2;
    logic [7:0]  w_len_ext;
    logic [15:0] w_sum_add;
    logic [15:0] w_rx_sum;

    assign w_pos_plus2 = {1'b0, i_state.position} + 8'd2;
    assign w_len_ext   = {1'b0, i_state.exp_len};
    assign w_sum_add   = i_state.sum + {8'h00, i_byte};
    assign w_rx_sum    = {i_state.sum_high, i_byte};

    always_comb begin
        o_state = i_state;
        o_step.event_res = EV_ACCEPT;
        o_step.byte_position = i_state.position;
        unique case (i_state.phase)
            PH_GOT_S, PH_GOT_N: begin
                if ((i_state.phase == PH_GOT_S && i_byte == HDR_N) ||
                    (i_state.phase == PH_GOT_N && i_byte == HDR_P)) begin
                    o_state.sum = w_sum_add;
                    o_state.phase = (i_state.phase == PH_GOT_S) ? PH_GOT_N : PH_TYPE;
                    o_state.position = i_state.position + 7'd1;
                end else begin
                    o_step.event_res = EV_HDR_ERR;
                    o_state.phase = PH_HUNT;
                    o_state.position = '0;
                end
            end
            PH_TYPE: begin
                o_state.kind = i_byte;
                case (i_byte[7:6])
                    SEL_BATCH: o_state.exp_len = {1'b0, i_byte[5:2], 2'b00} + LEN_SHORT;
                    SEL_DATA:  o_state.exp_len = LEN_DATA;
                    SEL_SHORT: o_state.exp_len = LEN_SHORT;
                    SEL_KEEP:  o_state.exp_len = i_state.exp_len;
                    default:   o_state.exp_len = i_state.exp_len;
                endcase
                o_state.sum = w_sum_add;
                o_state.phase = PH_ADDR;
                o_state.position = i_state.position + 7'd1;
            end
            PH_ADDR: begin
                o_state.addr = i_byte;
                o_state.sum = w_sum_add;
                o_state.phase = PH_BODY;
                o_state.position = i_state.position + 7'd1;
            end
            PH_BODY: begin
                if (w_pos_plus2 < w_len_ext) begin
                    o_step.event_res = EV_PAYLOAD;
                    o_state.sum = w_sum_add;
                    o_state.position = i_state.position + 7'd1;
                end else if (w_pos_plus2 == w_len_ext) begin
                    o_step.event_res = EV_SUM_HIGH;
                    o_state.sum_high = i_byte;
                    o_state.position = i_state.position + 7'd1;
                end else begin
                    o_step.event_res = (w_rx_sum == i_state.sum) ? EV_GOOD : EV_BAD;
                    o_state.phase = PH_HUNT;
                    o_state.position = '0;
                end
            end
            default: begin
                o_step.byte_position = '0;
                if (i_byte == HDR_S) begin
                    o_state.sum = {8'h00, i_byte};
                    o_state.phase = PH_GOT_S;
                    o_state.position = 7'd1;
                end else begin
                    o_step.event_res = EV_HDR_ERR;
                    o_state.phase = PH_HUNT;
                    o_state.position = '0;
                end
            end
        endcase
    end

endmodule

>>> rtl/sensor_packet_deframer_sum16_top.sv
// Top level of the sync-header packet deframer with a 16-bit sum check.
// Each byte is held in the input register, and its result is registered in the result register.
// Throughput: one byte per cycle while the output is not stalled; the state update in spd_step is combinational.
// Input and result registers let a new byte enter while a result waits.
// Reset is synchronous and active low; it returns the parser to hunting,
// sets the packet length to 7 and clears the sums and error counters.
`include "sensor_packet_deframer_sum16_top_macros.svh"

module sensor_packet_deframer_sum16_top #(
    parameter int ERROR_COUNT_WIDTH = spd_pkg::ERROR_COUNT_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spd_in_if.sink    i_in,
    spd_out_if.source o_out
);
    import spd_pkg::*;

    logic                         r_in_valid;
    logic [7:0]                   r_in_byte;
    logic                         r_out_valid;
    t_spd_result                  r_res;
    t_spd_result                  n_res;
    t_spd_state                   r_state;
    t_spd_state                   n_state;
    t_step_out                    w_step_out;
    logic [ERROR_COUNT_WIDTH-1:0] r_hdr_cnt;
    logic [ERROR_COUNT_WIDTH-1:0] n_hdr_cnt;
    logic [ERROR_COUNT_WIDTH-1:0] r_sum_cnt;
    logic [ERROR_COUNT_WIDTH-1:0] n_sum_cnt;
    logic                         w_step;

    assign w_step     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_step;

    spd_step u_step (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .o_state (n_state),
        .o_step  (w_step_out)
    );

    always_comb begin
        n_hdr_cnt = r_hdr_cnt;
        n_sum_cnt = r_sum_cnt;
        if (w_step_out.event_res == EV_HDR_ERR) begin
            n_hdr_cnt = r_hdr_cnt + ERROR_COUNT_WIDTH'(1);
        end
        if (w_step_out.event_res == EV_BAD) begin
            n_sum_cnt = r_sum_cnt + ERROR_COUNT_WIDTH'(1);
        end
        n_res.event_res            = w_step_out.event_res;
        n_res.byte_value           = r_in_byte;
        n_res.byte_position        = w_step_out.byte_position;
        n_res.packet_kind          = n_state.kind;
        n_res.register_address     = n_state.addr;
        n_res.frame_length         = n_state.exp_len;
        n_res.header_error_total   = 16'(n_hdr_cnt);
        n_res.checksum_error_total = 16'(n_sum_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_state.phase    <= PH_HUNT;
            r_state.position <= '0;
            r_state.exp_len  <= LEN_SHORT;
            r_state.kind     <= '0;
            r_state.addr     <= '0;
            r_state.sum      <= '0;
            r_state.sum_high <= '0;
            r_hdr_cnt        <= '0;
            r_sum_cnt        <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
                r_hdr_cnt   <= n_hdr_cnt;
                r_sum_cnt   <= n_sum_cnt;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.rx_byte;
        end
        if (w_step) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid                = r_out_valid;
    assign o_out.event_res            = r_res.event_res;
    assign o_out.byte_value           = r_res.byte_value;
    assign o_out.byte_position        = r_res.byte_position;
    assign o_out.packet_kind          = r_res.packet_kind;
    assign o_out.register_address     = r_res.register_address;
    assign o_out.frame_length         = r_res.frame_length;
    assign o_out.header_error_total   = r_res.header_error_total;
    assign o_out.checksum_error_total = r_res.checksum_error_total;

    // A buffered byte stays until the parser consumes it.
    `SPD_ASSERT(a_in_hold, i_clk, i_rst_n, (r_in_valid && !w_step) |=> r_in_valid)
    // Each header error advances the counter by exactly one.
    `SPD_ASSERT(a_hdr_count, i_clk, i_rst_n, (w_step && w_step_out.event_res == EV_HDR_ERR) |=> (r_hdr_cnt == $past(r_hdr_cnt) + ERROR_COUNT_WIDTH'(1)))
    // The packet length stays within the encodable range.
    `SPD_ASSERT(a_len_range, i_clk, i_rst_n, (r_state.exp_len >= LEN_SHORT) && (r_state.exp_len <= 7'd67))
    // In the body the position never reaches the packet length.
    `SPD_ASSERT(a_body_pos, i_clk, i_rst_n, (r_state.phase == PH_BODY) |-> (r_state.position < r_state.exp_len))

endmodule
